// ----- hdl/tsg_pkg.sv -----
// Package for the transient shaper gain core: sizes, register codes, item and
// configuration types, and the log2 and exp2 interpolation tables.
// Depends on nothing; every other file imports it.
`default_nettype none

package tsg_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int LOG_TABLE_DEPTH = 64;
  localparam int COEF_FRAC_BITS  = 32;
  localparam int ENV_BITS        = 48;
  localparam int ENV_SHIFT       = ENV_BITS - SAMPLE_BITS;
  localparam int COEF_W          = COEF_FRAC_BITS + 1;
  localparam int TAB_IDX_W       = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 33;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MID_COEF  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_COEF = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_COEF = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MONO      = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0]        mag;
  } item_t;

  typedef struct packed {
    logic [2:0][COEF_W-1:0] coef;      // mid, fast, slow
    logic signed [15:0]     attack;
    logic signed [16:0]     sustain;
    logic [17:0]            gain;
    logic                   mono;
  } cfg_t;

  typedef logic [31:0] tab_t [0:LOG_TABLE_DEPTH];

  // Integer square root, used only while the tables are built.
  function automatic longint unsigned isqrt64(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned xv;
    res  = 0;
    bitv = 64'd1 << 62;
    xv   = x;
    while (bitv > xv) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (xv >= res + bitv) begin
        xv  = xv - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Log table: floor(log2(1 + i/D) * 2^16) by repeated squaring.
  function automatic tab_t build_log_tab();
    tab_t            tab;
    longint unsigned m;
    logic [31:0]     y;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      m = (longint'(LOG_TABLE_DEPTH + i) << 30) / LOG_TABLE_DEPTH;
      y = '0;
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m    = m >> 1;
          y[k] = 1'b1;
        end
      end
      tab[i] = y;
    end
    tab[LOG_TABLE_DEPTH] = 32'd65536;
    return tab;
  endfunction

  // Exp table: 2^(i/D) in Q2.30 from products of 2^(2^-k).
  function automatic tab_t build_exp_tab();
    tab_t            tab;
    longint unsigned root [1:16];
    longint unsigned f16;
    longint unsigned r;
    root[1] = isqrt64(64'd1 << 61);
    for (int k = 2; k <= 16; k++) root[k] = isqrt64(root[k-1] << 30);
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      f16 = (longint'(i) << 16) / LOG_TABLE_DEPTH;
      r   = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        if (((f16 >> (16 - k)) & 64'd1) != 0) r = (r * root[k]) >> 30;
      end
      tab[i] = r[31:0];
    end
    tab[LOG_TABLE_DEPTH] = 32'h8000_0000;
    return tab;
  endfunction

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- hdl/tsg_front.sv -----
// Front stage: accepts a sample request, forms the envelope input magnitude
// and hands the item to the queue. Depends on tsg_pkg.
`default_nettype none

module tsg_front import tsg_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          mono,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  wire logic                          q_full,
  output logic                               q_push,
  output item_t                              q_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic [SAMPLE_BITS-1:0] mag_l;
  logic [SAMPLE_BITS-1:0] mag_r;

  // Magnitudes of both channels; the right one is ignored in mono.
  always_comb begin
    mag_l = in_left_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_left_sample)
                                          : SAMPLE_BITS'(in_left_sample);
    mag_r = in_right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_right_sample)
                                           : SAMPLE_BITS'(in_right_sample);
    item_nxt.left  = in_left_sample;
    item_nxt.right = in_right_sample;
    item_nxt.mag   = (mono || mag_l >= mag_r) ? mag_l : mag_r;
  end

  assign q_push   = valid_r && !q_full;
  assign in_ready = !valid_r || !q_full;
  assign q_item   = item_r;

  // Holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
        item_r  <= item_nxt;
      end else if (q_push) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tsg_queue.sv -----
// Two-entry queue between the front stage and the gain sequencer.
// Depends on tsg_pkg for the item type.
`default_nettype none

module tsg_queue import tsg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       q_valid,
  output item_t      q_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_item;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2))
    else $error("push into full queue");

endmodule

`default_nettype wire

// ----- hdl/tsg_back.sv -----
// Back sequencer: envelope updates, log2 ratios, exponent, exp2 gain and the
// saturated output register. Depends on tsg_pkg for tables and types.
`default_nettype none

module tsg_back import tsg_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  cfg_t                         cfg,
  input  wire logic                    q_valid,
  input  item_t                        q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);

  localparam int S         = SAMPLE_BITS;
  localparam int PH_W      = ENV_BITS - 24 + COEF_W;
  localparam int PL_W      = 24 + COEF_W;
  localparam int Q_W       = PH_W + 1;
  localparam int N_W       = Q_W + 1;
  localparam int POS_W     = $clog2(ENV_BITS);
  localparam int LOG_W     = POS_W + 16;
  localparam int RISE_W    = LOG_W - 1;
  localparam int TA_W      = 16 + LOG_W;
  localparam int TS_W      = 17 + LOG_W;
  localparam int ES_W      = TS_W + 1;
  localparam int E_W       = 22;
  localparam int N_SH_W    = E_W - 16;
  localparam int T_W       = 16 + TAB_IDX_W;
  localparam int GM_W      = 50;
  localparam int G_W       = 36;
  localparam int HI_W      = S + G_W;
  localparam int LO_W      = 16 + G_W;
  localparam int RES_W     = HI_W + 1;
  localparam int STEP_SH   = COEF_FRAC_BITS - 24;
  localparam logic signed [ES_W-1:0] E_LIM = ES_W'(64'd16 << 16);

  typedef enum logic [3:0] {
    S_IDLE, S_ENV_MUL, S_ENV_ADD, S_LOG_A, S_LOG_B, S_RISE, S_SUM,
    S_EXP_A, S_EXP_B, S_GAIN, S_OUT_MUL, S_OUT_SAT
  } state_t;

  state_t                       state_r;
  item_t                        item_r;
  logic [1:0]                   sel_r;
  logic [ENV_BITS-1:0]          env_r [3];
  logic [LOG_W-1:0]             log_r [3];
  logic [PH_W-1:0]              ph_r;
  logic [PL_W-1:0]              pl_r;
  logic                         neg_r;
  logic [POS_W-1:0]             p_r;
  logic [TAB_IDX_W-1:0]         idx_r;
  logic [15:0]                  rem_r;
  logic signed [TA_W-1:0]       ta_r;
  logic signed [TS_W-1:0]       ts_r;
  logic signed [E_W-1:0]        e_r;
  logic [47:0]                  eprod_r;
  logic [31:0]                  elo_r;
  logic signed [N_SH_W-1:0]     n_r;
  logic [GM_W-1:0]              gm_r;
  logic [G_W-1:0]               g_r;
  logic [HI_W-1:0]              lh_r, rh_r;
  logic [LO_W-1:0]              ll_r, rl_r;
  logic                         out_valid_r;
  logic signed [S-1:0]          left_r, right_r;

  logic [ENV_BITS-1:0]          env_cur, x_ext, d_val, env_nxt;
  logic                         neg_nxt;
  logic [PH_W-1:0]              ph_nxt;
  logic [PL_W-1:0]              pl_nxt;
  logic [Q_W-1:0]               q_val, step;
  logic signed [N_W-1:0]        n_val;
  logic [POS_W-1:0]             p_nxt;
  logic [15:0]                  frac;
  logic [T_W-1:0]               t_val;
  logic [16:0]                  llo, lhi;
  logic [32:0]                  lprod;
  logic [LOG_W-1:0]             log_nxt;
  logic [RISE_W-1:0]            rf, rs;
  logic signed [TA_W-1:0]       ta_nxt;
  logic signed [TS_W-1:0]       ts_nxt;
  logic signed [ES_W-1:0]       es, esh;
  logic signed [E_W-1:0]        e_nxt;
  logic [T_W-1:0]               et;
  logic [TAB_IDX_W-1:0]         eidx;
  logic [31:0]                  elo, ehi, mant;
  logic [47:0]                  eprod_nxt;
  logic [GM_W-1:0]              gm_nxt;
  logic [19:0]                  g_base;
  logic [N_SH_W-1:0]            n_neg;
  logic [G_W-1:0]               g_nxt;
  logic [S-1:0]                 mag_l, mag_rt;
  logic [RES_W-1:0]             res_l, res_r;
  logic signed [S-1:0]          left_nxt, right_nxt;
  logic                         out_free;

  // Saturating sign restore of a scaled magnitude.
  function automatic logic [S-1:0] sat_out(logic neg, logic [RES_W-1:0] r);
    logic [RES_W-1:0] maxp;
    logic [RES_W-1:0] negr;
    maxp = RES_W'({(S-1){1'b1}});
    negr = ~r + RES_W'(1);
    if (neg) begin
      return (r > maxp + RES_W'(1)) ? {1'b1, {(S-1){1'b0}}} : negr[S-1:0];
    end else begin
      return (r > maxp) ? {1'b0, {(S-1){1'b1}}} : r[S-1:0];
    end
  endfunction

  // Envelope step: one-pole update split into two partial products.
  always_comb begin
    env_cur = env_r[sel_r];
    x_ext   = ENV_BITS'(item_r.mag) << ENV_SHIFT;
    neg_nxt = x_ext < env_cur;
    d_val   = neg_nxt ? env_cur - x_ext : x_ext - env_cur;
    ph_nxt  = PH_W'(d_val[ENV_BITS-1:24]) * PH_W'(cfg.coef[sel_r]);
    pl_nxt  = PL_W'(d_val[23:0]) * PL_W'(cfg.coef[sel_r]);
    q_val   = Q_W'(ph_r) + Q_W'(pl_r >> 24);
    step    = q_val >> STEP_SH;
    n_val   = neg_r ? $signed(N_W'(env_cur)) - $signed(N_W'(step))
                    : $signed(N_W'(env_cur)) + $signed(N_W'(step));
    if (n_val < 0) env_nxt = '0;
    else if (n_val > $signed(N_W'({ENV_BITS{1'b1}}))) env_nxt = {ENV_BITS{1'b1}};
    else env_nxt = n_val[ENV_BITS-1:0];
  end

  // log2: leading one, mantissa, table interpolation.
  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < ENV_BITS; j++) begin
      if (env_cur[j]) p_nxt = POS_W'(j);
    end
    if (p_nxt >= POS_W'(16)) frac = 16'(env_cur >> (p_nxt - POS_W'(16)));
    else frac = 16'(env_cur << (POS_W'(16) - p_nxt));
    t_val   = T_W'(frac) * T_W'(LOG_TABLE_DEPTH);
    llo     = LOG_TAB[idx_r][16:0];
    lhi     = LOG_TAB[TAB_IDX_W'(idx_r + 1'b1)][16:0];
    lprod   = 33'(lhi - llo) * 33'(rem_r);
    log_nxt = LOG_W'({p_r, 16'b0}) + LOG_W'(llo) + LOG_W'(lprod >> 16);
  end

  // Shaping exponent: halved positive log ratios times the amounts.
  always_comb begin
    rf = (env_r[1] != 0 && env_r[0] != 0 && log_r[1] > log_r[0])
       ? RISE_W'((log_r[1] - log_r[0]) >> 1) : '0;
    rs = (env_r[2] != 0 && env_r[0] != 0 && log_r[2] > log_r[0])
       ? RISE_W'((log_r[2] - log_r[0]) >> 1) : '0;
    ta_nxt = TA_W'(cfg.attack) * TA_W'($signed({1'b0, rf}));
    ts_nxt = TS_W'(cfg.sustain) * TS_W'($signed({1'b0, rs}));
    es     = ES_W'(ta_r) + ES_W'(ts_r);
    esh    = es >>> 14;
    if (esh > E_LIM) e_nxt = E_W'(E_LIM);
    else if (esh < -E_LIM) e_nxt = E_W'(-E_LIM);
    else e_nxt = E_W'(esh);
  end

  // exp2 of the fraction, output volume and integer shift.
  always_comb begin
    et        = T_W'(e_r[15:0]) * T_W'(LOG_TABLE_DEPTH);
    eidx      = et[T_W-1:16];
    elo       = EXP_TAB[eidx];
    ehi       = EXP_TAB[TAB_IDX_W'(eidx + 1'b1)];
    eprod_nxt = 48'(ehi - elo) * 48'(et[15:0]);
    mant      = elo_r + 32'(eprod_r >> 16);
    gm_nxt    = GM_W'(cfg.gain) * GM_W'(mant);
    g_base    = gm_r[GM_W-1:30];
    n_neg     = N_SH_W'(-n_r);
    if (!n_r[N_SH_W-1]) g_nxt = G_W'(g_base) << n_r;
    else g_nxt = G_W'(g_base) >> n_neg;
  end

  // Output scaling and saturation.
  always_comb begin
    mag_l  = item_r.left[S-1] ? S'(-item_r.left) : S'(item_r.left);
    mag_rt = item_r.right[S-1] ? S'(-item_r.right) : S'(item_r.right);
    res_l  = RES_W'(lh_r) + RES_W'(ll_r >> 16);
    res_r  = RES_W'(rh_r) + RES_W'(rl_r >> 16);
    left_nxt  = sat_out(item_r.left[S-1], res_l);
    right_nxt = cfg.mono ? '0 : sat_out(item_r.right[S-1], res_r);
  end

  assign out_free      = !out_valid_r || out_ready;
  assign q_pop         = (state_r == S_IDLE) && q_valid;
  assign out_valid     = out_valid_r;
  assign out_left_out  = left_r;
  assign out_right_out = right_r;

  // Sequencer: state, envelopes and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 2'd0;
      out_valid_r <= 1'b0;
      env_r[0]    <= '0;
      env_r[1]    <= '0;
      env_r[2]    <= '0;
    end else begin
      // The output step sets valid itself when it loads a new result.
      if (out_valid_r && out_ready && state_r != S_OUT_SAT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            sel_r   <= 2'd0;
            state_r <= S_ENV_MUL;
          end
        end
        S_ENV_MUL: begin
          ph_r    <= ph_nxt;
          pl_r    <= pl_nxt;
          neg_r   <= neg_nxt;
          state_r <= S_ENV_ADD;
        end
        S_ENV_ADD: begin
          env_r[sel_r] <= env_nxt;
          if (sel_r == 2'd2) begin
            sel_r   <= 2'd0;
            state_r <= S_LOG_A;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= S_ENV_MUL;
          end
        end
        S_LOG_A: begin
          p_r     <= p_nxt;
          idx_r   <= t_val[T_W-1:16];
          rem_r   <= t_val[15:0];
          state_r <= S_LOG_B;
        end
        S_LOG_B: begin
          log_r[sel_r] <= log_nxt;
          if (sel_r == 2'd2) begin
            sel_r   <= 2'd0;
            state_r <= S_RISE;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= S_LOG_A;
          end
        end
        S_RISE: begin
          ta_r    <= ta_nxt;
          ts_r    <= ts_nxt;
          state_r <= S_SUM;
        end
        S_SUM: begin
          e_r     <= e_nxt;
          state_r <= S_EXP_A;
        end
        S_EXP_A: begin
          eprod_r <= eprod_nxt;
          elo_r   <= elo;
          n_r     <= e_r[E_W-1:16];
          state_r <= S_EXP_B;
        end
        S_EXP_B: begin
          gm_r    <= gm_nxt;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          g_r     <= g_nxt;
          state_r <= S_OUT_MUL;
        end
        S_OUT_MUL: begin
          lh_r    <= HI_W'(mag_l >> 16) * HI_W'(g_r);
          ll_r    <= LO_W'(mag_l[15:0]) * LO_W'(g_r);
          rh_r    <= HI_W'(mag_rt >> 16) * HI_W'(g_r);
          rl_r    <= LO_W'(mag_rt[15:0]) * LO_W'(g_r);
          state_r <= S_OUT_SAT;
        end
        S_OUT_SAT: begin
          if (out_free) begin
            left_r      <= left_nxt;
            right_r     <= right_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n) sel_r != 2'd3)
    else $error("envelope select out of range");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_SAT && out_valid_r && !out_ready) |=> state_r == S_OUT_SAT)
    else $error("result overwritten while stalled");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT_SAT)
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

// ----- hdl/transient_shaper_gain_core.sv -----
// Each accepted request passes the front register and the queue, then the back
// sequencer steps through envelopes, log2, exponent, exp2 gain and output.
// The back sequencer takes a new request only after its last result is loaded;
// it runs the three envelopes and three log2 lookups through one shared unit.
// Reset (synchronous, rst_n low) loads default registers and zero envelopes.
// Top level: configuration registers, front stage, queue and back sequencer.
// Depends on tsg_pkg, tsg_front, tsg_queue and tsg_back.
`default_nettype none

module transient_shaper_gain_core import tsg_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_left_out,
  output logic signed [SAMPLE_BITS-1:0]      out_right_out
);

  cfg_t  cfg_r;
  logic  q_full, q_push, q_pop, q_valid;
  item_t f_item, q_item;

  assign cfg_ready = 1'b1;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef[0] <= COEF_W'(2683515);
      cfg_r.coef[1] <= COEF_W'(110404582);
      cfg_r.coef[2] <= COEF_W'(268427);
      cfg_r.attack  <= '0;
      cfg_r.sustain <= '0;
      cfg_r.gain    <= 18'd65536;
      cfg_r.mono    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MID_COEF:  cfg_r.coef[0] <= cfg_data[COEF_W-1:0];
        REG_FAST_COEF: cfg_r.coef[1] <= cfg_data[COEF_W-1:0];
        REG_SLOW_COEF: cfg_r.coef[2] <= cfg_data[COEF_W-1:0];
        REG_ATTACK:    cfg_r.attack  <= cfg_data[15:0];
        REG_SUSTAIN:   cfg_r.sustain <= cfg_data[16:0];
        REG_GAIN:      cfg_r.gain    <= cfg_data[17:0];
        REG_MONO:      cfg_r.mono    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tsg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .mono            (cfg_r.mono),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (f_item)
  );

  tsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tsg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

`default_nettype wire
